[hdl/wcts_pkg.sv]
`default_nettype none
package wcts_pkg;
	localparam logic [25:0] DIST_MIN = 26'd7;
	localparam logic [19:0] LINE_MAX = 20'hFFFFF;
	localparam logic [26:0] Q27_MAX = 27'h7FFFFFF;
	localparam int unsigned REG_TEX_W = 0;
	localparam int unsigned REG_TEX_H = 1;

	typedef struct packed {
		logic [10:0] column;
		logic [1:0]  texture;
		logic        mirror;
	} side_t;
endpackage
`default_nettype wire

[hdl/wall_column_texture_setup_unit.sv]
`default_nettype none
// Wall column texture setup unit.
// Input channel s_axis_*: one ray hit per item. Output channel m_axis_*:
// one wall-strip descriptor per item. Config channel cfg_*: index 0 sets
// texture width, index 1 texture height; write only while idle.
// Every item passes a fixed pipeline: a stage for distance clamp and the
// hit-point product, clog2(SCREEN_HEIGHT)+17 stages of a bit-per-stage
// line-height divider (26 at a height of 512), a stage for bounds and texture
// column, 27 stages of a second divider for the texture step, a multiply stage
// and a final output register. Throughput is one item per clock while the
// receiver does not stall.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled receiver holds every stage and back-pressures s_axis_tready;
// no item is lost or repeated.
// Reset clears all valid bits and loads 64x64 texture size.
module wall_column_texture_setup_unit #(
	parameter int unsigned SCREEN_HEIGHT = 512
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// column[10:0], player_x[34:11], player_y[58:35], ray_dir_x[76:59],
	// ray_dir_y[94:77], wall_distance[120:95], texture_index[122:121]
	input  wire logic [127:0] s_axis_tdata,
	// hit_side
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// column_out[10:0], texture_out[12:11], line_height[32:13],
	// draw_start[41:33], draw_end[50:42], texel_column[60:51],
	// texel_step[87:61], texel_row_start[114:88]
	output logic      [119:0] m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [10:0]  cfg_data
);
	localparam int unsigned HW = $clog2(SCREEN_HEIGHT) + 1;
	localparam logic [HW-1:0] HALF = HW'(SCREEN_HEIGHT / 2);
	localparam logic [HW-1:0] SCR_LAST = HW'(SCREEN_HEIGHT - 1);
	localparam int unsigned N1 = HW + 16;
	localparam int unsigned N2 = 27;

	logic [10:0] tex_w_q, tex_h_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q <= 11'd64;
			tex_h_q <= 11'd64;
		end else if (cfg_valid) begin
			if (cfg_index == 1'(wcts_pkg::REG_TEX_W)) tex_w_q <= cfg_data;
			else tex_h_q <= cfg_data;
		end
	end
	logic [10:0] w_eff, h_eff;
	assign w_eff = (tex_w_q == '0) ? 11'd1 : tex_w_q;
	assign h_eff = (tex_h_q == '0) ? 11'd1 : tex_h_q;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1
	logic [10:0] column;
	logic [23:0] px, py;
	logic signed [17:0] dx, dy;
	logic [25:0] wall_dist, dcl;
	logic [1:0] tid;
	logic side;
	assign column = s_axis_tdata[10:0];
	assign px = s_axis_tdata[34:11];
	assign py = s_axis_tdata[58:35];
	assign dx = s_axis_tdata[76:59];
	assign dy = s_axis_tdata[94:77];
	assign wall_dist = s_axis_tdata[120:95];
	assign tid = s_axis_tdata[122:121];
	assign side = s_axis_tuser;
	assign dcl = (wall_dist < wcts_pkg::DIST_MIN) ? wcts_pkg::DIST_MIN : wall_dist;

	logic [15:0] frac;
	logic signed [44:0] prod;
	logic [23:0] pbase;
	always_comb begin
		prod = $signed({1'b0, dcl}) * (side ? dx : dy);
		pbase = side ? px : py;
		frac = pbase[15:0] + prod[31:16];
	end

	wcts_pkg::side_t sd_s1;
	logic [15:0] frac_s1;
	logic v_s1;
	logic [25:0] d_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.column  <= column;
			sd_s1.texture <= tid;
			sd_s1.mirror  <= side ? dy[17] : (!dx[17] && dx != '0);
			frac_s1 <= frac;
			d_s1 <= dcl;
		end
	end

	// line-height divider
	localparam int unsigned T1 = 16 + $bits(wcts_pkg::side_t);
	logic [N1-1:0] lh_q;
	logic [T1-1:0] t1o;
	logic v_s2;
	logic [N1-1:0] vsh1;
	wcts_div #(.NW(N1), .DW(26), .TW(T1)) u_div_lh (
		.clk(clk), .en(en),
		.num(N1'(SCREEN_HEIGHT) << 16), .den(d_s1),
		.tag_in({frac_s1, sd_s1}), .quo(lh_q), .tag_out(t1o)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vsh1 <= '0;
		else if (en) vsh1 <= {vsh1[N1-2:0], v_s1};
	end
	assign v_s2 = vsh1[N1-1];

	// stage 3: bounds and texture column
	logic [19:0] lh;
	logic [19:0] lh2;
	logic [HW-1:0] start, fin;
	logic [26:0] fw;
	logic [10:0] tx;
	wcts_pkg::side_t sd2;
	logic [15:0] fr2;
	always_comb begin
		fr2 = t1o[T1-1 -: 16];
		sd2 = t1o[$bits(wcts_pkg::side_t)-1:0];
		lh = (lh_q > N1'(wcts_pkg::LINE_MAX)) ? wcts_pkg::LINE_MAX : lh_q[19:0];
		lh2 = lh >> 1;
		start = (lh2 > 20'(HALF)) ? '0 : HW'(20'(HALF) - lh2);
		fin = (20'(lh2) + 20'(HALF) >= 20'(SCREEN_HEIGHT)) ? SCR_LAST : HW'(lh2 + 20'(HALF));
		fw = 27'(fr2) * 27'(w_eff);
		tx = fw[26:16];
		if (sd2.mirror) tx = w_eff - tx - 11'd1;
	end
	logic v_s3;
	logic [19:0] lh_s3;
	logic [HW-1:0] st_s3, en_s3;
	logic [9:0] tx_s3;
	wcts_pkg::side_t sd_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lh_s3 <= lh; st_s3 <= start; en_s3 <= fin;
			tx_s3 <= tx[9:0]; sd_s3 <= sd2;
		end
	end

	// step divider
	localparam int unsigned T2 = 20 + 2 * HW + 10 + $bits(wcts_pkg::side_t);
	logic [19:0] leff;
	logic [N2-1:0] step_q;
	logic [T2-1:0] t2o;
	logic [N2-1:0] vsh2;
	assign leff = (lh_s3 == '0) ? 20'd1 : lh_s3;
	wcts_div #(.NW(N2), .DW(20), .TW(T2)) u_div_st (
		.clk(clk), .en(en),
		.num({h_eff, 16'd0}), .den(leff),
		.tag_in({lh_s3, st_s3, en_s3, tx_s3, sd_s3}), .quo(step_q), .tag_out(t2o)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vsh2 <= '0;
		else if (en) vsh2 <= {vsh2[N2-2:0], v_s3};
	end

	// stage 5: row start product
	logic [19:0] lh5;
	logic [HW-1:0] st5, en5;
	logic [9:0] tx5;
	wcts_pkg::side_t sd5;
	logic signed [21:0] t2v;
	logic [20:0] t2c;
	assign {lh5, st5, en5, tx5, sd5} = t2o;
	always_comb begin
		t2v = 22'({st5, 1'b0}) - 22'(SCREEN_HEIGHT) + 22'(lh5 == '0 ? 20'd1 : lh5);
		t2c = t2v[21] ? '0 : t2v[20:0];
	end
	logic v_s5;
	logic [47:0] pr_s5;
	logic [26:0] step_s5;
	logic [19:0] lh_s5;
	logic [HW-1:0] st_s5, en_s5;
	logic [9:0] tx_s5;
	wcts_pkg::side_t sd_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= vsh2[N2-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s5 <= 48'(t2c * step_q);
			step_s5 <= step_q; lh_s5 <= lh5; st_s5 <= st5; en_s5 <= en5;
			tx_s5 <= tx5; sd_s5 <= sd5;
		end
	end

	logic [46:0] pos;
	assign pos = pr_s5[47:1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {5'd0,
				(pos > 47'(wcts_pkg::Q27_MAX)) ? wcts_pkg::Q27_MAX : pos[26:0],
				step_s5, tx_s5, 9'(en_s5), 9'(st_s5), lh_s5,
				sd_s5.texture, sd_s5.column};
		end
	end

	a_tready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("tready");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[41:33] <= m_axis_tdata[50:42] || m_axis_tdata[32:13] == '0)
		else $error("bounds");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && !m_axis_tready) |-> m_axis_tvalid) else $error("hold");
endmodule
`default_nettype wire

[hdl/wcts_div.sv]
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module wcts_div #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 26,
	parameter int unsigned TW = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] tag_in,
	output logic      [NW-1:0] quo,
	output logic      [TW-1:0] tag_out
);
	logic [NW-1:0] q_s [NW+1];
	logic [NW-1:0] n_s [NW+1];
	logic [DW:0]   r_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic [TW-1:0] t_s [NW+1];

	assign q_s[0] = '0;
	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign t_s[0] = tag_in;

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW+1:0] trial;
		logic [DW:0]   nr;
		always_comb begin
			trial = {r_s[i], n_s[i][NW-1]} - {2'b00, d_s[i]};
			nr    = trial[DW+1] ? {r_s[i][DW-1:0], n_s[i][NW-1]} : trial[DW:0];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1] <= nr;
				q_s[i+1] <= {q_s[i][NW-2:0], ~trial[DW+1]};
				n_s[i+1] <= {n_s[i][NW-2:0], 1'b0};
				d_s[i+1] <= d_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
	end

	assign quo     = q_s[NW];
	assign tag_out = t_s[NW];
endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	localparam int unsigned SCREEN_H = 512;
	localparam int unsigned PIPE_LAT = 70;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [26:0] texel_row_start;
		logic [26:0] texel_step;
		logic [9:0]  texel_column;
		logic [8:0]  row_last;
		logic [8:0]  row_first;
		logic [19:0] line_height;
		logic [1:0]  texture;
		logic [10:0] column;
	} strip_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [119:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [10:0] cfg_data;

	logic [10:0] tex_width;
	logic [10:0] tex_height;
	strip_t pending_strips[$];
	int mismatches;
	int idle_pct;
	longint unsigned cycles = 0;

	wall_column_texture_setup_unit #(.SCREEN_HEIGHT(SCREEN_H)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic strip_t predict_strip(logic [10:0] col, logic [23:0] px, logic [23:0] py,
			logic signed [17:0] dx, logic signed [17:0] dy, logic [25:0] wall_dist, logic side,
			logic [1:0] tex);
		strip_t s;
		longint unsigned d, w, h, lh, leff, start, stop, frac, tx, step, pos, sum;
		longint t2, prod;
		d = wall_dist;
		w = (tex_width == 0) ? 1 : tex_width;
		h = (tex_height == 0) ? 1 : tex_height;
		if (d < wcts_pkg::DIST_MIN)
			d = wcts_pkg::DIST_MIN;
		lh = (longint'(SCREEN_H) << 16) / d;
		if (lh > wcts_pkg::LINE_MAX)
			lh = wcts_pkg::LINE_MAX;
		start = (lh / 2 > SCREEN_H / 2) ? 0 : SCREEN_H / 2 - lh / 2;
		stop = lh / 2 + SCREEN_H / 2;
		if (stop >= SCREEN_H)
			stop = SCREEN_H - 1;
		if (!side) begin
			prod = longint'(d) * longint'(dy);
			sum = (longint'(py) << 16) + prod;
		end else begin
			prod = longint'(d) * longint'(dx);
			sum = (longint'(px) << 16) + prod;
		end
		frac = (sum >> 16) & 64'hFFFF;
		tx = (frac * w) >> 16;
		if ((!side && dx > 0) || (side && dy < 0))
			tx = w - tx - 1;
		leff = (lh == 0) ? 1 : lh;
		step = (h << 16) / leff;
		t2 = 2 * longint'(start) - longint'(SCREEN_H) + longint'(leff);
		if (t2 < 0)
			t2 = 0;
		pos = (longint'(t2) * step) >> 1;
		if (pos > wcts_pkg::Q27_MAX)
			pos = wcts_pkg::Q27_MAX;
		if (step > wcts_pkg::Q27_MAX)
			step = wcts_pkg::Q27_MAX;
		s.column = col;
		s.texture = tex;
		s.line_height = lh[19:0];
		s.row_first = start[8:0];
		s.row_last = stop[8:0];
		s.texel_column = tx[9:0];
		s.texel_step = step[26:0];
		s.texel_row_start = pos[26:0];
		return s;
	endfunction

	task automatic send_ray(logic [10:0] col, logic [23:0] px, logic [23:0] py,
			logic [17:0] dx, logic [17:0] dy, logic [25:0] wall_dist, logic side,
			logic [1:0] tex);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {5'd0, tex, wall_dist, dy, dx, py, px, col};
		s_axis_tuser <= side;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_strips.push_back(predict_strip(col, px, py, dx, dy, wall_dist, side, tex));
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		while (pending_strips.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == 1'(wcts_pkg::REG_TEX_W))
			tex_width = val;
		else
			tex_height = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_ray(int unsigned dist_kind);
		logic [25:0] wall_dist;
		case (dist_kind % 4)
			0: wall_dist = 26'($urandom_range(0, 16));
			1: wall_dist = 26'($urandom_range(16, 200000));
			2: wall_dist = 26'($urandom_range(60000, 1500000));
			default: wall_dist = 26'($urandom);
		endcase
		send_ray(11'($urandom), 24'($urandom), 24'($urandom), 18'($urandom), 18'($urandom),
			wall_dist, 1'($urandom), 2'($urandom));
	endtask

	task automatic test_directed();
		send_ray(11'd0, 24'd0, 24'd0, 18'h00000, 18'h00000, 26'd0, 1'b0, 2'd0);
		send_ray(11'h7FF, 24'hFFFFFF, 24'hFFFFFF, 18'h1FFFF, 18'h1FFFF, 26'h3FFFFFF, 1'b1, 2'd3);
		send_ray(11'd5, 24'h012345, 24'h0ABCDE, 18'h20000, 18'h20000, 26'd6, 1'b0, 2'd1);
		send_ray(11'd6, 24'h012345, 24'h0ABCDE, 18'h20000, 18'h20000, 26'd7, 1'b1, 2'd2);
		send_ray(11'd7, 24'h018000, 24'h028000, 18'h10000, 18'h08000, 26'h10000, 1'b0, 2'd0);
		send_ray(11'd8, 24'h018000, 24'h028000, 18'h10000, 18'h38000, 26'h10000, 1'b1, 2'd1);
		send_ray(11'd9, 24'h018000, 24'h028000, 18'h30000, 18'h08000, 26'h10000, 1'b0, 2'd2);
		send_ray(11'd10, 24'h018000, 24'h028000, 18'h30000, 18'h08000, 26'h10000, 1'b1, 2'd3);
		send_ray(11'd11, 24'h040000, 24'h040000, 18'h00001, 18'h3FFFF, 26'd32768, 1'b0, 2'd0);
		send_ray(11'd12, 24'h040000, 24'h040000, 18'h00001, 18'h3FFFF, 26'd65535, 1'b1, 2'd1);
		send_ray(11'd13, 24'h000001, 24'hFFFF00, 18'h3FFFF, 18'h00001, 26'd33554432, 1'b0, 2'd2);
		send_ray(11'd14, 24'h000001, 24'hFFFF00, 18'h3FFFF, 18'h00001, 26'd33554433, 1'b1, 2'd3);
		send_ray(11'd15, 24'h0F0F0F, 24'hF0F0F0, 18'h15555, 18'h2AAAA, 26'd65537, 1'b0, 2'd0);
		send_ray(11'd16, 24'hF0F0F0, 24'h0F0F0F, 18'h2AAAA, 18'h15555, 26'd131072, 1'b1, 2'd1);
	endtask

	task automatic test_texture_sizes();
		logic [10:0] sizes[6] = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd37, 11'd64};
		for (int i = 0; i < 6; i++) begin
			drain_pipe();
			write_reg(1'(wcts_pkg::REG_TEX_W), sizes[i]);
			write_reg(1'(wcts_pkg::REG_TEX_H), sizes[(i + 2) % 6]);
			test_directed();
			for (int k = 0; k < 60; k++)
				random_ray(k);
		end
	endtask

	task automatic test_random_stream();
		for (int k = 0; k < 1200; k++) begin
			if (k % 300 == 0) begin
				drain_pipe();
				write_reg(1'(wcts_pkg::REG_TEX_W), 11'($urandom_range(1, 1024)));
				write_reg(1'(wcts_pkg::REG_TEX_H), 11'($urandom_range(1, 1024)));
			end
			idle_pct = (k >= 400 && k < 550) ? 0 : 14;
			random_ray($urandom);
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= (idle_pct == 0) || ($urandom_range(99) >= 14);

	always @(posedge clk) begin
		strip_t want;
		strip_t got;
		cycles <= cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = strip_t'(m_axis_tdata[114:0]);
			if (pending_strips.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected strip %h", got);
			end else begin
				want = pending_strips.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("col %0d: exp %h got %h", want.column, want, got);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		tex_width = 11'd64;
		tex_height = 11'd64;
		mismatches = 0;
		idle_pct = 14;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_texture_sizes();
		test_random_stream();
		idle_pct = 14;
		drain_pipe();
		if (mismatches == 0 && pending_strips.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hdl/wcts_pkg.sv
hdl/wcts_div.sv
hdl/wall_column_texture_setup_unit.sv
bench/testbench.sv
